FILE: hw/rtl/steering_frame_translator_core_assert.svh
// ----------------------------------------------------------------------------
// Steering frame translator assertion macros
// Shared property forms for the translator core checks.
// ----------------------------------------------------------------------------
`ifndef STEERING_FRAME_TRANSLATOR_CORE_ASSERT_SVH
`define STEERING_FRAME_TRANSLATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define SFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sft_pkg.sv
// ----------------------------------------------------------------------------
// Steering frame translator package
// Transaction types and fixed constants shared by the translator modules.
// ----------------------------------------------------------------------------
package sft_pkg;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  angle_low;
        logic [7:0]  angle_high;
        logic [7:0]  rate_raw;
    } t_frame_in;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  out_angle_low;
        logic [7:0]  out_angle_high;
        logic [7:0]  out_rate;
        logic [7:0]  out_marker;
        logic [7:0]  out_check;
    } t_frame_out;

    localparam logic [10:0] FRAME_ID_OK   = 11'h0C4;
    localparam logic [3:0]  FRAME_LEN_MIN = 4'd5;
    localparam logic [7:0]  MARKER_BYTE   = 8'h07;

    // Angle: |s| * 45 / 100 = ((|s| * 9) >> 2) / 5, divide by 5 via reciprocal.
    localparam logic [12:0] ANGLE_LIMIT  = 13'd7200;
    localparam logic [16:0] DIV5_RECIP   = 17'd52429;   // ceil(2^18 / 5)

    // Rate: mag * 190 / 65 = mag * 38 / 13, folded into one constant.
    localparam logic [17:0] RATE_RECIP   = 18'd191596;  // 38 * ceil(2^16 / 13)
    localparam logic [7:0]  RATE_MAX     = 8'd255;

endpackage

FILE: hw/rtl/sft_angle.sv
// ----------------------------------------------------------------------------
// Steering frame translator angle path
// Scale the signed angle by 0.45 toward zero, negate and clamp to +/-7200.
// ----------------------------------------------------------------------------
module sft_angle
    import sft_pkg::*;
(
    input  logic [7:0]  i_angle_low,
    input  logic [7:0]  i_angle_high,
    output logic [15:0] o_angle
);

    logic [15:0] raw;
    logic        neg;
    logic [16:0] mag;
    logic [19:0] mag9;
    logic [16:0] quarter;
    logic [33:0] prod;
    logic [13:0] quot;
    logic [12:0] clamped;

    assign raw  = {i_angle_high, i_angle_low};
    assign neg  = raw[15];
    assign mag  = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    assign mag9 = {mag, 3'b000} + {3'b000, mag};
    // mag9 stays below 2^19, so bits [18:2] hold the quarter exactly
    assign quarter = mag9[18:2];
    assign prod    = quarter * DIV5_RECIP;
    assign quot    = prod[31:18];

    assign clamped = (quot > {1'b0, ANGLE_LIMIT}) ? ANGLE_LIMIT : quot[12:0];

    // Negate: a negative input gives a positive result
    assign o_angle = neg ? {3'b000, clamped} : (16'd0 - {3'b000, clamped});

endmodule

FILE: hw/rtl/sft_rate.sv
// ----------------------------------------------------------------------------
// Steering frame translator rate path
// Take the rate magnitude, scale by 190/65 and saturate at 255.
// ----------------------------------------------------------------------------
module sft_rate
    import sft_pkg::*;
(
    input  logic [7:0] i_rate_raw,
    output logic [7:0] o_rate
);

    logic [7:0]  mag;
    logic [25:0] prod;
    logic [9:0]  scaled;

    // -128 maps to 8'h80, read as an unsigned 128
    assign mag    = i_rate_raw[7] ? (8'd0 - i_rate_raw) : i_rate_raw;
    assign prod   = mag * RATE_RECIP;
    assign scaled = prod[25:16];
    assign o_rate = (scaled > {2'b00, RATE_MAX}) ? RATE_MAX : scaled[7:0];

endmodule

FILE: hw/rtl/steering_frame_translator_core.sv
// ----------------------------------------------------------------------------
// Steering frame translator core
// Pipeline: 2 register stages, input then result; a result stalled by i_out_ready holds both.
// Throughput: 1 transaction per cycle while i_out_ready holds; the angle multiplier sets the path.
// Reset: synchronous active low; clears valids and the rolling counter to 0.
// ----------------------------------------------------------------------------
module steering_frame_translator_core
    import sft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_frame_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_frame_out o_out_data
);

    // Input register stage
    logic       r_s1_vld, n_s1_vld;
    t_frame_in  r_s1, n_s1;

    // Result register stage
    logic       r_out_vld, n_out_vld;
    t_frame_out r_out, n_out;

    // Rolling counter, advanced only by accepted frames
    logic [3:0] r_seq, n_seq;

    logic        adv;
    logic        frame_ok;
    logic [15:0] angle;
    logic [7:0]  rate;
    logic [7:0]  fold;
    logic [3:0]  csum;

    // Move the input stage forward when the result register is free or draining
    assign adv        = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || adv;

    sft_angle u_angle (
        .i_angle_low  (r_s1.angle_low),
        .i_angle_high (r_s1.angle_high),
        .o_angle      (angle)
    );

    sft_rate u_rate (
        .i_rate_raw (r_s1.rate_raw),
        .o_rate     (rate)
    );

    // Accept only the steering identifier with at least five data bytes
    assign frame_ok = (r_s1.frame_id == FRAME_ID_OK) && (r_s1.frame_len >= FRAME_LEN_MIN);

    // Fold the XOR of the payload bytes and counter into one nibble
    assign fold = angle[7:0] ^ angle[15:8] ^ rate ^ MARKER_BYTE ^ {4'b0000, r_seq};
    assign csum = fold[3:0] ^ fold[7:4];

    always_comb begin
        n_s1_vld = r_s1_vld;
        n_s1     = r_s1;
        if (o_in_ready) begin
            n_s1_vld = i_in_valid;
            n_s1     = i_in_data;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_seq     = r_seq;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (adv) begin
            n_out_vld = 1'b1;
            if (frame_ok) begin
                n_out.accepted       = 1'b1;
                n_out.out_angle_low  = angle[7:0];
                n_out.out_angle_high = angle[15:8];
                n_out.out_rate       = rate;
                n_out.out_marker     = MARKER_BYTE;
                n_out.out_check      = {csum, r_seq};
                n_seq                = r_seq + 4'd1;
            end else begin
                // Drop the frame: every field reads zero, counter holds
                n_out = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_seq     <= 4'd0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            r_seq     <= n_seq;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "steering_frame_translator_core_assert.svh"

    // A rejected result carries all-zero fields
    `SFT_ASSERT_NOW(a_reject_zero,
        o_out_valid && !o_out_data.accepted,
        o_out_data == '0,
        "rejected result has nonzero fields")

    // An accepted result carries the marker byte
    `SFT_ASSERT_NOW(a_marker,
        o_out_valid && o_out_data.accepted,
        o_out_data.out_marker == MARKER_BYTE,
        "accepted result marker byte wrong")

    // The output angle always stays inside the clamp range
    `SFT_ASSERT_NOW(a_angle_range,
        o_out_valid && o_out_data.accepted,
        ($signed({o_out_data.out_angle_high, o_out_data.out_angle_low}) <= 16'sd7200)
        && ($signed({o_out_data.out_angle_high, o_out_data.out_angle_low}) >= -16'sd7200),
        "output angle outside clamp range")

    // The counter holds unless an accepted frame moves into the result register
    `SFT_ASSERT_NEXT(a_seq_hold,
        !(adv && frame_ok),
        $stable(r_seq),
        "rolling counter moved without an accepted frame")

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Steering frame translator core testbench
// Sends steering-sensor frames through the translator under random sender and
// receiver idling. A scoreboard works out each translated frame on its own and
// checks the results field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import sft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT  = 4000;   // cycles without any transaction
    localparam int TAIL_CYCLES  = 8;      // idle margin at the end of the run
    localparam int HOLD_CYCLES  = 64;     // long receiver hold-off
    localparam int SHOW_LIMIT   = 10;

    // Translation constants of the frame format.
    localparam int ANGLE_MUL  = 45;
    localparam int ANGLE_DIV  = 100;
    localparam int ANGLE_CLIP = 7200;
    localparam int RATE_MUL   = 190;
    localparam int RATE_DIV   = 65;
    localparam int RATE_CLIP  = 255;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each translated frame and checks it on arrival.
    // ------------------------------------------------------------------------
    class translation_board;
        logic [3:0] roll_cnt;
        t_frame_out translated_q[$];
        int         err_cnt;
        int         shown_cnt;

        function new();
            roll_cnt  = '0;
            err_cnt   = 0;
            shown_cnt = 0;
        endfunction

        // Translate one frame; advance the rolling counter on accepted frames.
        function t_frame_out translate_frame(t_frame_in f);
            t_frame_out r;
            int         s;
            int         ang;
            int         mag;
            int         rate;
            logic [7:0] x;
            r = '0;
            if (f.frame_id != FRAME_ID_OK || f.frame_len < FRAME_LEN_MIN) begin
                return r;
            end
            s   = $signed({f.angle_high, f.angle_low});
            ang = -((s * ANGLE_MUL) / ANGLE_DIV);
            if (ang > ANGLE_CLIP) begin
                ang = ANGLE_CLIP;
            end else if (ang < -ANGLE_CLIP) begin
                ang = -ANGLE_CLIP;
            end
            mag  = f.rate_raw[7] ? 256 - int'(f.rate_raw) : int'(f.rate_raw);
            rate = (mag * RATE_MUL) / RATE_DIV;
            if (rate > RATE_CLIP) begin
                rate = RATE_CLIP;
            end
            r.accepted       = 1'b1;
            r.out_angle_low  = ang[7:0];
            r.out_angle_high = ang[15:8];
            r.out_rate       = rate[7:0];
            r.out_marker     = MARKER_BYTE;
            x = r.out_angle_low ^ r.out_angle_high ^ r.out_rate ^ r.out_marker
                ^ {4'h0, roll_cnt};
            r.out_check = {x[3:0] ^ x[7:4], roll_cnt};
            roll_cnt++;
            return r;
        endfunction

        function void note_frame(t_frame_in f);
            translated_q.push_back(translate_frame(f));
        endfunction

        function void report(string msg);
            err_cnt++;
            if (shown_cnt < SHOW_LIMIT) begin
                shown_cnt++;
                $display("[%0t] MISMATCH %s", $realtime, msg);
            end
        endfunction

        function void check_field(string label, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                report($sformatf("%s: expected %02h, got %02h", label, want, got));
            end
        endfunction

        function void check_result(t_frame_out got);
            t_frame_out want;
            if (translated_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = translated_q.pop_front();
            check_field("accepted",       {7'h0, want.accepted}, {7'h0, got.accepted});
            check_field("out_angle_low",  want.out_angle_low,    got.out_angle_low);
            check_field("out_angle_high", want.out_angle_high,   got.out_angle_high);
            check_field("out_rate",       want.out_rate,         got.out_rate);
            check_field("out_marker",     want.out_marker,       got.out_marker);
            check_field("out_check",      want.out_check,        got.out_check);
        endfunction

        function int outstanding();
            return translated_q.size();
        endfunction

        function int final_errors();
            return err_cnt + translated_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_frame_in  i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_frame_out o_out_data;

    translation_board board = new();

    int  rx_stall_pct;      // receiver stall rate, percent of cycles
    int  hold_off_reqs;     // long hold-offs asked for by the main sequence
    int  hold_off_done;     // long hold-offs carried out by the receiver
    int  quiet_cycles;

    steering_frame_translator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic t_frame_in make_frame(logic [10:0] id, logic [3:0] len,
                                             logic [15:0] angle, logic [7:0] rate);
        t_frame_in f;
        f.frame_id   = id;
        f.frame_len  = len;
        f.angle_low  = angle[7:0];
        f.angle_high = angle[15:8];
        f.rate_raw   = rate;
        return f;
    endfunction

    // Mostly well-formed frames; the rest carry a short length or a random id.
    function automatic t_frame_in random_frame();
        int          pick;
        logic [10:0] id;
        logic [3:0]  len;
        logic [15:0] angle;
        pick = $urandom_range(99);
        if (pick < 75) begin
            id  = FRAME_ID_OK;
            len = 4'($urandom_range(15, 5));
        end else if (pick < 85) begin
            id  = FRAME_ID_OK;
            len = 4'($urandom_range(4, 0));
        end else begin
            id  = 11'($urandom_range(2047));
            len = 4'($urandom_range(15));
        end
        // Half full-range angles, half in -17000..17000 across the clamp boundary.
        if ($urandom_range(1)) begin
            angle = 16'($urandom);
        end else begin
            angle = 16'($urandom_range(17000) - ($urandom_range(1) ? 0 : 17000));
        end
        return make_frame(id, len, angle, 8'($urandom));
    endfunction

    // Offer one frame from the next falling edge and hold it until taken.
    task automatic send_frame(t_frame_in f);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_frame(f);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Hold the input quiet until every predicted result has come back.
    task automatic drain();
        idle_cycle();
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int n_items, int tx_idle_pct, int rx_pct);
        rx_stall_pct = rx_pct;
        repeat (n_items) begin
            while ($urandom_range(99) < tx_idle_pct) idle_cycle();
            send_frame(random_frame());
        end
    endtask

    task automatic run_directed();
        t_frame_in dir_q[$];
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd5,  16'h0000, 8'h00));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd8,  16'h7FFF, 8'h7F));
        // most negative angle and most negative rate
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd15, 16'h8000, 8'h80));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd9,  16'hFFFF, 8'hFF));
        // right at the clamp, then just past it, both signs
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd5,  16'h3E80, 8'd88));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd5,  16'hC180, 8'd87));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd6,  16'h3E83, 8'd22));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd7,  16'hC17D, 8'h01));
        // rejected: short length, wrong ids
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd4,  16'h1234, 8'h10));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd0,  16'hFFFF, 8'hFF));
        dir_q.push_back(make_frame(11'h0C5,     4'd8,  16'h1000, 8'h20));
        dir_q.push_back(make_frame(11'h7FF,     4'd15, 16'hFFFF, 8'hFF));
        dir_q.push_back(make_frame(11'h000,     4'd8,  16'h0100, 8'h30));
        dir_q.push_back(make_frame(11'h4C4,     4'd8,  16'h0100, 8'h30));
        // accepted again: counter must not have moved on the rejects
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd5,  16'h0001, 8'h81));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd10, 16'hFFFE, 8'h40));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd12, 16'h0003, 8'hC0));
        dir_q.push_back(make_frame(FRAME_ID_OK, 4'd14, 16'hFFFD, 8'h56));
        foreach (dir_q[k]) send_frame(dir_q[k]);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_done != hold_off_reqs) begin
                hold_off_done++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_data);
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        rx_stall_pct  = 0;
        hold_off_reqs = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with a receiver that never stalls.
        run_directed();
        drain();

        // Sender mostly busy, receiver mostly stalled.
        run_phase(300, 6, 75);
        drain();

        // Sender mostly idle, receiver mostly ready.
        run_phase(300, 75, 6);
        drain();

        // Long receiver hold-off while frames keep coming: fill the block
        // and back-pressure the input, then run with no idling at all.
        hold_off_reqs++;
        run_phase(40, 0, 0);
        run_phase(260, 0, 0);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.final_errors() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
